// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LED node checkers. The
// enclosing scope must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while in reset.
`define DCN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Valid must stay up and the payload must hold while the transfer stalls.
`define DCN_ASSERT_HOLD(label, vld, stl, pld, msg) \
  `DCN_ASSERT(label, (vld && stl) |=> (vld && $stable(pld)), msg)

`endif

// ===== design/dcn_pkg.sv =====
// ----------------------------------------------------------------------------
// dcn_pkg
// Types and constants shared by the daisy chain RGB LED node.
// ----------------------------------------------------------------------------
`default_nettype none

package dcn_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned PdataW = 32;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [DataW-1:0] PeriodReset = 8'd255;
  localparam logic [DataW-1:0] LengthAdjust = 8'd3;

  // Opcode of an input item
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Register word index (paddr above the byte lane bits)
  localparam logic [PaddrW-3:0] RegPwmPeriod = 1'b0;

  typedef struct packed {
    logic             opcode;
    logic [DataW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic             tx_valid;
    logic [DataW-1:0] tx_byte;
    logic             red_pin;
    logic             green_pin;
    logic             blue_pin;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_FWD,
    CMD_RED,
    CMD_GREEN,
    CMD_BLUE,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/dcn_queue.sv =====
// ----------------------------------------------------------------------------
// dcn_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcn_queue #(
  parameter int unsigned Depth = dcn_pkg::FifoDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dcn_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output dcn_pkg::cmd_t      pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dcn_pkg::cmd_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == FullCnt);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entries_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/dcn_front.sv =====
// ----------------------------------------------------------------------------
// dcn_front
// Accepts input items, tracks the packet byte index and classifies each
// item into a forward, duty or tick command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dcn_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire dcn_pkg::in_item_t in_data_i,
  output logic                   in_stall_o,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dcn_pkg::cmd_t          q_cmd_o
);

  logic [dcn_pkg::DataW-1:0] byte_index_q, byte_index_d;
  logic [dcn_pkg::DataW-1:0] packet_length_q, packet_length_d;
  logic [dcn_pkg::DataW-1:0] length_now;
  logic                      is_byte;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign is_byte    = (in_data_i.opcode == dcn_pkg::OpByte);

  // The length byte itself decides where its own packet ends
  assign length_now = (byte_index_q == '0) ? in_data_i.rx_byte : packet_length_q;

  always_comb begin
    q_cmd_o.kind = dcn_pkg::CMD_TICK;
    q_cmd_o.data = in_data_i.rx_byte;
    if (is_byte) begin
      case (byte_index_q)
        8'd0: begin
          q_cmd_o.kind = dcn_pkg::CMD_FWD;
          q_cmd_o.data = in_data_i.rx_byte - dcn_pkg::LengthAdjust;
        end
        8'd1:    q_cmd_o.kind = dcn_pkg::CMD_RED;
        8'd2:    q_cmd_o.kind = dcn_pkg::CMD_GREEN;
        8'd3:    q_cmd_o.kind = dcn_pkg::CMD_BLUE;
        default: q_cmd_o.kind = dcn_pkg::CMD_FWD;
      endcase
    end
  end

  always_comb begin
    byte_index_d    = byte_index_q;
    packet_length_d = packet_length_q;
    if (q_push_o && is_byte) begin
      packet_length_d = length_now;
      byte_index_d    = (byte_index_q == length_now - 8'd1) ? '0 : byte_index_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q    <= '0;
      packet_length_q <= '0;
    end else begin
      byte_index_q    <= byte_index_d;
      packet_length_q <= packet_length_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/dcn_back.sv =====
// ----------------------------------------------------------------------------
// dcn_back
// Executes classified commands: duty updates, PWM counter ticks and byte
// forwarding, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcn_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [dcn_pkg::DataW-1:0] pwm_period_i,
  input  wire logic                      q_valid_i,
  input  wire dcn_pkg::cmd_t             q_cmd_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  output dcn_pkg::out_item_t             out_data_o,
  input  wire logic                      out_stall_i
);

  logic [dcn_pkg::DataW-1:0] red_q, red_d;
  logic [dcn_pkg::DataW-1:0] green_q, green_d;
  logic [dcn_pkg::DataW-1:0] blue_q, blue_d;
  logic [dcn_pkg::DataW-1:0] count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  dcn_pkg::out_item_t        out_data_q, result;

  // Advance when the output register is empty or being drained
  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = q_pop_o || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    red_d           = red_q;
    green_d         = green_q;
    blue_d          = blue_q;
    count_d         = count_q;
    result.tx_valid = 1'b0;
    result.tx_byte  = '0;
    case (q_cmd_i.kind)
      dcn_pkg::CMD_FWD: begin
        result.tx_valid = 1'b1;
        result.tx_byte  = q_cmd_i.data;
      end
      dcn_pkg::CMD_RED:   red_d   = q_cmd_i.data;
      dcn_pkg::CMD_GREEN: green_d = q_cmd_i.data;
      dcn_pkg::CMD_BLUE:  blue_d  = q_cmd_i.data;
      dcn_pkg::CMD_TICK:  count_d = (count_q >= pwm_period_i) ? '0 : count_q + 8'd1;
      default: ;
    endcase
    result.red_pin   = (count_d >= red_d) && (count_d < pwm_period_i);
    result.green_pin = (count_d >= green_d) && (count_d < pwm_period_i);
    result.blue_pin  = (count_d >= blue_d) && (count_d < pwm_period_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        red_q   <= red_d;
        green_q <= green_d;
        blue_q  <= blue_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire

// ===== design/daisy_chain_rgb_pwm_node.sv =====
// ----------------------------------------------------------------------------
// daisy_chain_rgb_pwm_node
// One node of a daisy chain of RGB LEDs with a three channel PWM output.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries serial bytes and PWM ticks.
// Each accepted item yields exactly one result on the output channel
// (out_valid_o / out_stall_i): the forwarded byte, if any, and the three pin
// levels after the item. The front end tracks the packet byte index and
// classifies items; a queue of FifoDepth entries feeds the back end, which
// holds the duties, the PWM counter and the output register.
// An accepted item is written into the queue and then popped into the output
// register, which drives the result until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall, limited by the single output register.
// When the receiver stalls, the output register holds its result, the queue
// fills and in_stall_o rises once FifoDepth items wait.
// Reset clears the byte index, packet length, duties and counter, sets
// pwm_period to 255 and empties the queue and output stage.
// pwm_period sits at word 0 (byte addresses 0 to 3) of the APB port; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module daisy_chain_rgb_pwm_node #(
  parameter int unsigned FifoDepth = dcn_pkg::FifoDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire dcn_pkg::in_item_t          in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output dcn_pkg::out_item_t              out_data_o,
  input  wire logic                       out_stall_i,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dcn_pkg::PaddrW-1:0] paddr,
  input  wire logic [dcn_pkg::PdataW-1:0] pwdata,
  output logic      [dcn_pkg::PdataW-1:0] prdata,
  output logic                            pready
);

  logic [dcn_pkg::DataW-1:0] pwm_period_q;
  logic                      q_full, q_push, q_valid, q_pop, sel_period;
  dcn_pkg::cmd_t             push_cmd, pop_cmd;

  assign pready     = 1'b1;
  assign sel_period = (paddr[dcn_pkg::PaddrW-1:2] == dcn_pkg::RegPwmPeriod);
  assign prdata     = sel_period ? {{(dcn_pkg::PdataW - dcn_pkg::DataW){1'b0}}, pwm_period_q}
                                 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_period_q <= dcn_pkg::PeriodReset;
    end else if (psel && penable && pwrite && pready && sel_period) begin
      pwm_period_q <= pwdata[dcn_pkg::DataW-1:0];
    end
  end

  dcn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  dcn_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  dcn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pwm_period_i (pwm_period_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

`default_nettype wire

// ===== design/dcn_checker.sv =====
// ----------------------------------------------------------------------------
// dcn_checker
// Port level checks for the LED node, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcn_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire dcn_pkg::in_item_t  in_data_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire dcn_pkg::out_item_t out_data_o,
  input wire logic               out_stall_i
);

  logic       out_xfer;
  logic       in_xfer;
  logic       fwd_xfer;
  logic       idle_res;
  logic [2:0] pins;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign fwd_xfer = out_xfer && out_data_o.tx_valid;
  assign idle_res = out_valid_o && !out_data_o.tx_valid;
  assign pins     = {out_data_o.red_pin, out_data_o.green_pin, out_data_o.blue_pin};

  `DCN_ASSERT_HOLD(a_in_hold, in_valid_i, in_stall_o, in_data_i, "input dropped while stalled")
  `DCN_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_data_o, "result not held")
  `DCN_ASSERT(a_tx_zero, idle_res |-> (out_data_o.tx_byte == '0), "idle tx byte not zero")
  // Forwarding a byte touches neither duties nor counter: pins follow the previous result
  `DCN_ASSERT(a_fwd_pins, (fwd_xfer && $past(out_xfer)) |-> (pins == $past(pins)), "pins moved")
  `DCN_ASSERT(a_no_spurious, $rose(out_valid_o) |-> $past(in_xfer, 2), "result without a transfer")

endmodule

bind daisy_chain_rgb_pwm_node dcn_checker u_dcn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_data_i   (in_data_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the daisy chain RGB LED node. Byte packets and PWM
// ticks are driven with random gaps against a randomly stalling receiver. A
// scoreboard class predicts the forwarded byte and the three pin levels for
// every input transfer and checks each output transfer against them, while
// the PWM period is reprogrammed over the APB port between traffic phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  typedef logic [dcn_pkg::DataW-1:0] byte_t;

  localparam int unsigned IdleLimit = 2000;
  localparam logic [dcn_pkg::PaddrW-1:0] PeriodAddr = {dcn_pkg::RegPwmPeriod, 2'b00};

  // Byte positions within a packet
  localparam byte_t IdxLength = 8'd0;
  localparam byte_t IdxRed = 8'd1;
  localparam byte_t IdxGreen = 8'd2;
  localparam byte_t IdxBlue = 8'd3;

  class packet_pwm_predictor;
    byte_t              period;
    byte_t              byte_idx;
    byte_t              length;
    byte_t              red;
    byte_t              green;
    byte_t              blue;
    byte_t              count;
    dcn_pkg::out_item_t expected_results[$];
    int                 errors;

    function new();
      period = dcn_pkg::PeriodReset;
      byte_idx = '0;
      length = '0;
      red = '0;
      green = '0;
      blue = '0;
      count = '0;
      errors = 0;
    endfunction

    function void set_period(byte_t value);
      period = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic pin_level(byte_t duty);
      return (count >= duty) && (count < period);
    endfunction

    function void note_item(dcn_pkg::in_item_t item);
      dcn_pkg::out_item_t res;
      byte_t              last_idx;
      res = '0;
      if (item.opcode == dcn_pkg::OpByte) begin
        case (byte_idx)
          IdxLength: begin
            length = item.rx_byte;
            res.tx_valid = 1'b1;
            res.tx_byte = item.rx_byte - dcn_pkg::LengthAdjust;
          end
          IdxRed: red = item.rx_byte;
          IdxGreen: green = item.rx_byte;
          IdxBlue: blue = item.rx_byte;
          default: begin
            res.tx_valid = 1'b1;
            res.tx_byte = item.rx_byte;
          end
        endcase
        // length zero gives a last index of 255, so the packet runs 256 bytes
        last_idx = length - 8'd1;
        byte_idx = (byte_idx == last_idx) ? '0 : byte_idx + 8'd1;
      end else begin
        count = (count >= period) ? '0 : count + 8'd1;
      end
      res.red_pin = pin_level(red);
      res.green_pin = pin_level(green);
      res.blue_pin = pin_level(blue);
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, byte_t want, byte_t got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dcn_pkg::out_item_t got);
      dcn_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $error("output transfer with no result awaited: %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("tx_valid", byte_t'(want.tx_valid), byte_t'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("red_pin", byte_t'(want.red_pin), byte_t'(got.red_pin));
      compare_field("green_pin", byte_t'(want.green_pin), byte_t'(got.green_pin));
      compare_field("blue_pin", byte_t'(want.blue_pin), byte_t'(got.blue_pin));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  dcn_pkg::in_item_t             in_item = '0;
  logic                          in_stall;
  logic                          out_valid;
  dcn_pkg::out_item_t            out_item;
  logic                          out_stall = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [dcn_pkg::PaddrW-1:0]    paddr = '0;
  logic [dcn_pkg::PdataW-1:0]    pwdata = '0;
  logic [dcn_pkg::PdataW-1:0]    prdata;
  logic                          pready;

  bit                  idle_en = 1'b1;
  bit                  stall_en = 1'b1;
  int                  items_sent = 0;
  int                  quiet_cycles = 0;
  int                  stall_left = 0;
  packet_pwm_predictor sb = new();

  always #10 clk = ~clk;

  daisy_chain_rgb_pwm_node dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_data_i  (in_item),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_item),
    .out_stall_i(out_stall),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (!stall_en) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Observe both channels and guard against a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic byte_t rand_byte(int unsigned hi);
    return byte_t'($urandom_range(0, hi));
  endfunction

  task automatic send_item(dcn_pkg::in_item_t item);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // let the monitor note the transfer before the scoreboard is read
    #1;
    items_sent++;
  endtask

  task automatic send_byte(byte_t value);
    dcn_pkg::in_item_t item;
    item.opcode = dcn_pkg::OpByte;
    item.rx_byte = value;
    send_item(item);
  endtask

  task automatic send_tick();
    dcn_pkg::in_item_t item;
    item.opcode = dcn_pkg::OpTick;
    item.rx_byte = rand_byte(255);
    send_item(item);
  endtask

  task automatic maybe_ticks(int pct);
    while ($urandom_range(0, 99) < pct) send_tick();
  endtask

  // Hold the sender until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(byte_t value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PeriodAddr;
    pwdata <= dcn_pkg::PdataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_period(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic byte_t pick_duty();
    if ($urandom_range(0, 1)) return rand_byte(sb.period);
    return rand_byte(255);
  endfunction

  // Finish any open packet so the next one starts on its length byte
  task automatic align_packet();
    while (sb.byte_idx != IdxLength) send_byte(rand_byte(255));
  endtask

  task automatic send_packet(int len, int tick_pct);
    align_packet();
    send_byte(byte_t'(len));
    for (int j = 1; j < ((len == 0) ? 256 : len); j++) begin
      maybe_ticks(tick_pct);
      if (j <= IdxBlue) send_byte(pick_duty());
      else send_byte(rand_byte(255));
    end
  endtask

  task automatic traffic(int n, int tick_pct);
    int start;
    int sel;
    start = items_sent;
    while (items_sent - start < n) begin
      sel = $urandom_range(0, 19);
      maybe_ticks(tick_pct);
      if (sel < 2) begin
        // broken sequence: one to three stray items, with length bytes drawn from 0 to 12
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) send_tick();
          else if (sb.byte_idx == IdxLength) send_byte(rand_byte(12));
          else send_byte(rand_byte(255));
        end
      end else if (sel < 14) begin
        send_packet($urandom_range(4, 10), tick_pct);
      end else if (sel < 17) begin
        send_packet($urandom_range(1, 3), tick_pct);
      end else begin
        send_packet($urandom_range(11, 30), tick_pct);
      end
    end
  endtask

  task automatic directed_items();
    send_tick();
    send_byte(8'd4);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd1);
    send_tick();
    send_tick();
    send_byte(8'd1);
    send_byte(8'd2);
    send_byte(8'd5);
    send_byte(8'd3);
    send_byte(8'd0);
    send_byte(8'd0);
    send_byte(8'd6);
    send_byte(8'd0);
    send_byte(8'd1);
    send_byte(8'd2);
    send_byte(8'd255);
    send_byte(8'd0);
    send_tick();
    send_tick();
    send_tick();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset period first, then a spread of settings
    directed_items();
    drain();
    write_period(8'd4);
    traffic(100, 50);
    drain();
    write_period(8'd1);
    send_packet(0, 2);
    traffic(50, 40);
    drain();
    write_period(8'd255);
    traffic(120, 85);
    drain();
    traffic(50, 85);
    // lowering the period can leave the counter above it
    drain();
    write_period(8'd20);
    traffic(120, 50);
    drain();
    write_period(rand_byte(252) + 8'd2);
    traffic(100, 50);
    drain();
    idle_en = 1'b0;
    stall_en = 1'b0;
    write_period(rand_byte(15) + 8'd1);
    traffic(100, 50);
    drain();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
